@@ rtl/bie_pkg.sv @@
`default_nettype none
package bie_pkg;
    localparam int unsigned NUM_VARIABLES_DEF = 64;
    localparam int unsigned NUM_LABELS_DEF = 32;
    localparam int unsigned CURSOR_BITS_DEF = 16;

    localparam logic [7:0] END_BYTE = 8'hBA;
    localparam logic [7:0] ERR_TERMINATOR = 8'hA0;
    localparam logic [7:0] ERR_OPCODE = 8'hB1;
    localparam logic [7:0] ERR_ASSIGN = 8'h01;
    localparam logic [7:0] ERR_MOVE = 8'h02;
    localparam logic [7:0] ERR_NOT = 8'h07;
    localparam logic [7:0] ERR_BOOL = 8'h08;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_EXIT = 3'd1;
    localparam logic [2:0] ST_PROG_ERR = 3'd2;
    localparam logic [2:0] ST_USER_ERR = 3'd3;
    localparam logic [2:0] ST_NOT_LABEL = 3'd4;

    localparam logic [7:0] OP_ASSIGN = 8'd0;
    localparam logic [7:0] OP_MOVE = 8'd1;
    localparam logic [7:0] OP_ADD = 8'd2;
    localparam logic [7:0] OP_SUB = 8'd3;
    localparam logic [7:0] OP_MUL = 8'd4;
    localparam logic [7:0] OP_DIV = 8'd5;
    localparam logic [7:0] OP_INCR = 8'd6;
    localparam logic [7:0] OP_DECR = 8'd7;
    localparam logic [7:0] OP_NOT = 8'd8;
    localparam logic [7:0] OP_BOOL = 8'd9;
    localparam logic [7:0] OP_EQ = 8'd10;
    localparam logic [7:0] OP_GT = 8'd11;
    localparam logic [7:0] OP_LT = 8'd12;
    localparam logic [7:0] OP_LABEL = 8'd13;
    localparam logic [7:0] OP_JUMP = 8'd14;
    localparam logic [7:0] OP_CJUMP = 8'd15;
    localparam logic [7:0] OP_RETURN = 8'd16;
    localparam logic [7:0] OP_DEBUG = 8'd17;
    localparam logic [7:0] OP_UERR = 8'd18;
    localparam logic [7:0] OP_SETFN = 8'd19;
    localparam logic [7:0] OP_CALL = 8'd20;
    localparam logic [7:0] OP_EXIT = 8'd21;

    localparam logic [0:0] REG_VARIABLE_TAG = 1'b0;
    localparam logic [0:0] REG_IMMEDIATE_TAG = 1'b1;

    // Operation code handed to the shared arithmetic unit.
    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_EQ,
        ALU_GT,
        ALU_LT
    } alu_op_t;

    typedef struct packed {
        logic start;
        alu_op_t op;
    } alu_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_sts_t;
endpackage
`default_nettype wire

@@ rtl/bie_if.sv @@
`default_nettype none
interface bie_in_if #(parameter int unsigned CURSOR_BITS = bie_pkg::CURSOR_BITS_DEF);
    logic valid;
    logic ready;
    logic cmd;
    logic [7:0] opcode;
    logic [7:0] type_a;
    logic [7:0] operand_a;
    logic [7:0] type_b;
    logic [7:0] operand_b;
    logic [7:0] type_c;
    logic [7:0] operand_c;
    logic [7:0] end_marker;
    logic [CURSOR_BITS-1:0] cursor;

    modport source (output valid, cmd, opcode, type_a, operand_a, type_b, operand_b,
                    type_c, operand_c, end_marker, cursor, input ready);
    modport sink (input valid, cmd, opcode, type_a, operand_a, type_b, operand_b,
                  type_c, operand_c, end_marker, cursor, output ready);
endinterface

interface bie_out_if #(parameter int unsigned CURSOR_BITS = bie_pkg::CURSOR_BITS_DEF);
    logic valid;
    logic ready;
    logic [2:0] status;
    logic [7:0] error_code;
    logic debug_valid;
    logic [7:0] debug_value;
    logic call_valid;
    logic [7:0] call_function;
    logic [7:0] call_arg_one;
    logic [7:0] call_arg_two;
    logic [7:0] call_arg_three;
    logic [CURSOR_BITS-1:0] next_cursor;
    logic jumped;

    modport source (output valid, status, error_code, debug_valid, debug_value, call_valid,
                    call_function, call_arg_one, call_arg_two, call_arg_three,
                    next_cursor, jumped, input ready);
    modport sink (input valid, status, error_code, debug_valid, debug_value, call_valid,
                  call_function, call_arg_one, call_arg_two, call_arg_three,
                  next_cursor, jumped, output ready);
endinterface
`default_nettype wire

@@ rtl/bie_alu.sv @@
`default_nettype none
// Shared 8-bit arithmetic unit. Add, subtract, multiply and compares are
// registered at start; divide runs restoring, one quotient bit per cycle.
module bie_alu (
    input wire logic clk,
    input wire logic rst_n,
    input wire bie_pkg::alu_ctl_t ctl,
    input wire logic [7:0] x,
    input wire logic [7:0] y,
    output bie_pkg::alu_sts_t sts,
    output logic [7:0] result
);
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] quo_reg, quo_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] div_reg, div_next;
    logic [7:0] res_reg, res_next;
    logic [15:0] prod;
    logic [8:0] trial;
    logic [8:0] shifted;

    assign prod = {8'd0, x} * {8'd0, y};
    assign shifted = {rem_reg, quo_reg[7]};
    assign trial = shifted - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        res_next = res_reg;
        if (busy_reg)
        begin
            if (trial[8])
            begin
                rem_next = shifted[7:0];
                quo_next = {quo_reg[6:0], 1'b0};
            end
            else
            begin
                rem_next = trial[7:0];
                quo_next = {quo_reg[6:0], 1'b1};
            end
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next = quo_next;
            end
        end
        else if (ctl.start)
        begin
            case (ctl.op)
                bie_pkg::ALU_ADD: res_next = x + y;
                bie_pkg::ALU_SUB: res_next = x - y;
                bie_pkg::ALU_MUL: res_next = prod[7:0];
                bie_pkg::ALU_EQ: res_next = {7'd0, x == y};
                bie_pkg::ALU_GT: res_next = {7'd0, x > y};
                bie_pkg::ALU_LT: res_next = {7'd0, x < y};
                bie_pkg::ALU_DIV: res_next = 8'hFF;
                default: res_next = 8'd0;
            endcase
            if (ctl.op == bie_pkg::ALU_DIV && y != 8'd0)
            begin
                busy_next = 1'b1;
                cnt_next = 3'd0;
                quo_next = x;
                rem_next = 8'd0;
                div_next = y;
            end
            else
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        res_reg <= res_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

@@ rtl/bytecode_instruction_executor.sv @@
`default_nettype none
// Bytecode instruction executor. One beat on the input channel carries one
// eight-byte instruction; the block answers each with exactly one result beat.
// Execution is sequential: an instruction is taken, then its three operands
// are read from the variable file one per cycle. The file has a single read
// port, and operands a, b and c are always fetched, whatever their tags. A
// decode state follows. Arithmetic and compares then run on the shared
// arithmetic unit, the result is written back, and the result beat is
// offered. Add, subtract, multiply, the compares and a divide by zero pass
// through a start state (S_ALU) and a wait state (S_WAIT) before the result
// beat is offered. A divide by a nonzero value stays in S_WAIT while the
// eight-step iterative divider runs, so it sets the worst case. Input ready
// is low while an instruction is in flight or its result has not been taken.
// After reset the variable file is cleared by a sweep over all NUM_VARIABLES
// entries, during which no instruction is accepted. The label table is held
// in flip-flops and clears at once. Configuration writes (variable and
// immediate type tags) may be made at any time the block is idle.
module bytecode_instruction_executor #(
    parameter int unsigned NUM_VARIABLES = bie_pkg::NUM_VARIABLES_DEF,
    parameter int unsigned NUM_LABELS = bie_pkg::NUM_LABELS_DEF,
    parameter int unsigned CURSOR_BITS = bie_pkg::CURSOR_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    bie_in_if.sink in_ch,
    bie_out_if.source out_ch,
    input wire logic cfg_we,
    input wire logic [0:0] cfg_index,
    input wire logic [7:0] cfg_data
);
    localparam int unsigned VB = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;
    localparam int unsigned LB = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
    localparam int unsigned CB = VB + 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_DECODE,
        S_ALU,
        S_WAIT,
        S_OUT
    } state_t;

    state_t state_reg;
    logic [CB-1:0] clr_reg;
    logic [7:0] vtag_reg, itag_reg;

    // Latched instruction.
    logic cmd_reg;
    logic [7:0] op_reg, ta_reg, va_reg, tb_reg, vb_reg, tc_reg, vc_reg, end_reg;
    logic [CURSOR_BITS-1:0] cur_reg;
    // Resolved operands (variable value read, or the operand byte itself).
    logic [7:0] xa_reg, xb_reg, xc_reg;

    logic [7:0] vars_mem [NUM_VARIABLES];
    logic [7:0] rd_data_reg;
    logic [VB-1:0] rd_addr;
    logic wr_en;
    logic [VB-1:0] wr_addr;
    logic [7:0] wr_data;

    logic [CURSOR_BITS-1:0] labels_reg [NUM_LABELS];
    logic [CURSOR_BITS-1:0] ret_reg;
    logic [7:0] ufn_reg, err_reg;

    logic [2:0] o_status_reg;
    logic o_dbg_v_reg, o_call_v_reg, o_jumped_reg;
    logic [7:0] o_dbg_reg, o_cf_reg, o_c1_reg, o_c2_reg, o_c3_reg;
    logic [CURSOR_BITS-1:0] o_next_reg;

    bie_pkg::alu_ctl_t alu_ctl;
    bie_pkg::alu_sts_t alu_sts;
    logic [7:0] alu_res;

    bie_alu u_alu (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(alu_ctl),
        .x(xa_reg),
        .y(xb_reg),
        .sts(alu_sts),
        .result(alu_res)
    );

    // A tag that matches the variable tag wins when both tags are equal.
    function automatic logic is_var(input logic [7:0] t, input logic [7:0] vt);
        return t == vt;
    endfunction

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);

    // Read address follows the operand being fetched this cycle.
    always_comb
    begin
        case (state_reg)
            S_IDLE: rd_addr = in_ch.operand_a[VB-1:0];
            S_RD_A: rd_addr = vb_reg[VB-1:0];
            S_RD_B: rd_addr = vc_reg[VB-1:0];
            default: rd_addr = va_reg[VB-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vars_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= vars_mem[rd_addr];
    end

    logic alu_class;
    assign alu_class = (op_reg >= bie_pkg::OP_ADD && op_reg <= bie_pkg::OP_DIV)
        || (op_reg >= bie_pkg::OP_EQ && op_reg <= bie_pkg::OP_LT);

    always_comb
    begin
        alu_ctl.start = (state_reg == S_ALU);
        case (op_reg)
            bie_pkg::OP_ADD: alu_ctl.op = bie_pkg::ALU_ADD;
            bie_pkg::OP_SUB: alu_ctl.op = bie_pkg::ALU_SUB;
            bie_pkg::OP_MUL: alu_ctl.op = bie_pkg::ALU_MUL;
            bie_pkg::OP_DIV: alu_ctl.op = bie_pkg::ALU_DIV;
            bie_pkg::OP_EQ: alu_ctl.op = bie_pkg::ALU_EQ;
            bie_pkg::OP_GT: alu_ctl.op = bie_pkg::ALU_GT;
            default: alu_ctl.op = bie_pkg::ALU_LT;
        endcase
    end

    // Write port: clearing sweep, decode-time writes, or the ALU result.
    logic dec_we;
    logic [VB-1:0] dec_wa;
    logic [7:0] dec_wd;
    logic [7:0] raw_a;

    always_comb
    begin
        raw_a = rd_data_reg;
        dec_we = 1'b0;
        dec_wa = va_reg[VB-1:0];
        dec_wd = 8'd0;
        if (state_reg == S_DECODE && end_reg == bie_pkg::END_BYTE && !cmd_reg)
        begin
            case (op_reg)
                bie_pkg::OP_ASSIGN:
                begin
                    dec_we = is_var(ta_reg, vtag_reg) && tb_reg == itag_reg;
                    dec_wd = vb_reg;
                end
                bie_pkg::OP_MOVE:
                begin
                    dec_we = is_var(ta_reg, vtag_reg) && is_var(tb_reg, vtag_reg);
                    dec_wa = vb_reg[VB-1:0];
                    dec_wd = raw_a;
                end
                bie_pkg::OP_INCR:
                begin
                    dec_we = 1'b1;
                    dec_wd = raw_a + 8'd1;
                end
                bie_pkg::OP_DECR:
                begin
                    dec_we = 1'b1;
                    dec_wd = raw_a - 8'd1;
                end
                bie_pkg::OP_NOT:
                begin
                    dec_we = is_var(ta_reg, vtag_reg);
                    dec_wd = {7'd0, raw_a == 8'd0};
                end
                bie_pkg::OP_BOOL:
                begin
                    dec_we = is_var(ta_reg, vtag_reg);
                    dec_wd = {7'd0, raw_a != 8'd0};
                end
                default: dec_we = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            wr_en = 1'b1;
            wr_addr = clr_reg[VB-1:0];
            wr_data = 8'd0;
        end
        else if (state_reg == S_WAIT && alu_sts.done)
        begin
            wr_en = 1'b1;
            wr_addr = vc_reg[VB-1:0];
            wr_data = alu_res;
        end
        else
        begin
            wr_en = dec_we;
            wr_addr = dec_wa;
            wr_data = dec_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            vtag_reg <= 8'd0;
            itag_reg <= 8'd1;
            ret_reg <= '0;
            ufn_reg <= 8'd0;
            err_reg <= 8'd0;
            xa_reg <= 8'd0;
            xb_reg <= 8'd0;
            xc_reg <= 8'd0;
            o_status_reg <= bie_pkg::ST_OK;
            o_dbg_v_reg <= 1'b0;
            o_dbg_reg <= 8'd0;
            o_call_v_reg <= 1'b0;
            o_cf_reg <= 8'd0;
            o_c1_reg <= 8'd0;
            o_c2_reg <= 8'd0;
            o_c3_reg <= 8'd0;
            o_next_reg <= '0;
            o_jumped_reg <= 1'b0;
            for (int i = 0; i < NUM_LABELS; i++)
            begin
                labels_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == bie_pkg::REG_VARIABLE_TAG)
                begin
                    vtag_reg <= cfg_data;
                end
                else
                begin
                    itag_reg <= cfg_data;
                end
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CB'(NUM_VARIABLES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        state_reg <= S_RD_A;
                    end
                end
                S_RD_A:
                begin
                    xa_reg <= is_var(ta_reg, vtag_reg) ? rd_data_reg : va_reg;
                    state_reg <= S_RD_B;
                end
                S_RD_B:
                begin
                    xb_reg <= is_var(tb_reg, vtag_reg) ? rd_data_reg : vb_reg;
                    state_reg <= S_RD_C;
                end
                S_RD_C:
                begin
                    xc_reg <= is_var(tc_reg, vtag_reg) ? rd_data_reg : vc_reg;
                    state_reg <= S_DECODE;
                end
                S_DECODE:
                begin
                    o_status_reg <= bie_pkg::ST_OK;
                    o_dbg_v_reg <= 1'b0;
                    o_dbg_reg <= 8'd0;
                    o_call_v_reg <= 1'b0;
                    o_cf_reg <= 8'd0;
                    o_c1_reg <= 8'd0;
                    o_c2_reg <= 8'd0;
                    o_c3_reg <= 8'd0;
                    o_next_reg <= cur_reg;
                    o_jumped_reg <= 1'b0;
                    state_reg <= S_OUT;
                    if (end_reg != bie_pkg::END_BYTE)
                    begin
                        err_reg <= bie_pkg::ERR_TERMINATOR;
                        o_status_reg <= bie_pkg::ST_PROG_ERR;
                    end
                    else if (cmd_reg)
                    begin
                        if (op_reg == bie_pkg::OP_LABEL)
                        begin
                            labels_reg[xa_reg[LB-1:0]] <= cur_reg;
                        end
                        else if (op_reg == bie_pkg::OP_EXIT)
                        begin
                            o_status_reg <= bie_pkg::ST_EXIT;
                        end
                        else
                        begin
                            o_status_reg <= bie_pkg::ST_NOT_LABEL;
                        end
                    end
                    else if (op_reg == bie_pkg::OP_ASSIGN)
                    begin
                        if (!is_var(ta_reg, vtag_reg) || tb_reg != itag_reg)
                        begin
                            err_reg <= bie_pkg::ERR_ASSIGN;
                            o_status_reg <= bie_pkg::ST_PROG_ERR;
                        end
                    end
                    else if (op_reg == bie_pkg::OP_MOVE)
                    begin
                        if (!is_var(ta_reg, vtag_reg) || !is_var(tb_reg, vtag_reg))
                        begin
                            err_reg <= bie_pkg::ERR_MOVE;
                            o_status_reg <= bie_pkg::ST_PROG_ERR;
                        end
                    end
                    else if (alu_class)
                    begin
                        if (!is_var(tc_reg, vtag_reg))
                        begin
                            err_reg <= (op_reg <= bie_pkg::OP_DIV) ? op_reg + 8'd1
                                                                    : op_reg - 8'd1;
                            o_status_reg <= bie_pkg::ST_PROG_ERR;
                        end
                        else
                        begin
                            state_reg <= S_ALU;
                        end
                    end
                    else
                    begin
                        case (op_reg)
                            bie_pkg::OP_INCR, bie_pkg::OP_DECR: ;
                            bie_pkg::OP_NOT:
                            begin
                                if (!is_var(ta_reg, vtag_reg))
                                begin
                                    err_reg <= bie_pkg::ERR_NOT;
                                    o_status_reg <= bie_pkg::ST_PROG_ERR;
                                end
                            end
                            bie_pkg::OP_BOOL:
                            begin
                                if (!is_var(ta_reg, vtag_reg))
                                begin
                                    err_reg <= bie_pkg::ERR_BOOL;
                                    o_status_reg <= bie_pkg::ST_PROG_ERR;
                                end
                            end
                            bie_pkg::OP_LABEL: labels_reg[xa_reg[LB-1:0]] <= cur_reg;
                            bie_pkg::OP_JUMP:
                            begin
                                ret_reg <= cur_reg;
                                o_next_reg <= labels_reg[xa_reg[LB-1:0]];
                                o_jumped_reg <= 1'b1;
                            end
                            bie_pkg::OP_CJUMP:
                            begin
                                if (xa_reg == xb_reg)
                                begin
                                    o_next_reg <= labels_reg[xc_reg[LB-1:0]];
                                    o_jumped_reg <= 1'b1;
                                end
                            end
                            bie_pkg::OP_RETURN:
                            begin
                                o_next_reg <= ret_reg;
                                o_jumped_reg <= 1'b1;
                            end
                            bie_pkg::OP_DEBUG:
                            begin
                                o_dbg_v_reg <= 1'b1;
                                o_dbg_reg <= xa_reg;
                            end
                            bie_pkg::OP_UERR:
                            begin
                                err_reg <= xa_reg;
                                o_status_reg <= bie_pkg::ST_USER_ERR;
                            end
                            bie_pkg::OP_SETFN: ufn_reg <= xa_reg;
                            bie_pkg::OP_CALL:
                            begin
                                o_call_v_reg <= 1'b1;
                                o_cf_reg <= ufn_reg;
                                o_c1_reg <= xa_reg;
                                o_c2_reg <= xb_reg;
                                o_c3_reg <= xc_reg;
                            end
                            bie_pkg::OP_EXIT: o_status_reg <= bie_pkg::ST_EXIT;
                            default:
                            begin
                                err_reg <= bie_pkg::ERR_OPCODE;
                                o_status_reg <= bie_pkg::ST_PROG_ERR;
                            end
                        endcase
                    end
                end
                S_ALU: state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (alu_sts.done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Instruction latch; payload only, no reset needed.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            cmd_reg <= in_ch.cmd;
            op_reg <= in_ch.opcode;
            ta_reg <= in_ch.type_a;
            va_reg <= in_ch.operand_a;
            tb_reg <= in_ch.type_b;
            vb_reg <= in_ch.operand_b;
            tc_reg <= in_ch.type_c;
            vc_reg <= in_ch.operand_c;
            end_reg <= in_ch.end_marker;
            cur_reg <= in_ch.cursor;
        end
    end

    // The decode writes of incr/decr/not/bool/move use the value read for
    // operand a, which the read port fetches again while operand c is taken.
    assign out_ch.status = o_status_reg;
    assign out_ch.error_code = err_reg;
    assign out_ch.debug_valid = o_dbg_v_reg;
    assign out_ch.debug_value = o_dbg_reg;
    assign out_ch.call_valid = o_call_v_reg;
    assign out_ch.call_function = o_cf_reg;
    assign out_ch.call_arg_one = o_c1_reg;
    assign out_ch.call_arg_two = o_c2_reg;
    assign out_ch.call_arg_three = o_c3_reg;
    assign out_ch.next_cursor = o_next_reg;
    assign out_ch.jumped = o_jumped_reg;

    // Input is refused whenever a result beat is pending.
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("input ready while result pending");

    // A pending result beat holds until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result beat dropped");

    // The divider is only busy while the sequencer waits for it.
    a_alu_busy: assert property (@(posedge clk) disable iff (!rst_n)
        alu_sts.busy |-> (state_reg == S_WAIT))
        else $error("divider busy outside wait");

    // Only one of debug and call output can be raised in a result.
    a_dbg_call: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.debug_valid && out_ch.call_valid))
        else $error("debug and call both set");
endmodule
`default_nettype wire

@@ sim/bie_tb_if.sv @@
`timescale 1ns / 1ps
// The block's channel interfaces (bie_in_if, bie_out_if) come with the RTL.
// This file adds the configuration write port that the test drives.
interface bie_cfg_if;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;

    modport source (output cfg_we, cfg_index, cfg_data);
    modport sink (input cfg_we, cfg_index, cfg_data);
endinterface

@@ sim/bie_checker.sv @@
`timescale 1ns / 1ps
module bie_checker (
    input wire logic clk,
    input wire logic rst_n,
    bie_in_if.sink in_mon,
    bie_out_if.sink out_mon,
    bie_cfg_if.sink cfg_mon,
    output int errors
);
    localparam int unsigned VB = $clog2(bie_pkg::NUM_VARIABLES_DEF);
    localparam int unsigned LB = $clog2(bie_pkg::NUM_LABELS_DEF);

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] error_code;
        logic debug_valid;
        logic [7:0] debug_value;
        logic call_valid;
        logic [7:0] call_function;
        logic [7:0] call_arg_one;
        logic [7:0] call_arg_two;
        logic [7:0] call_arg_three;
        logic [15:0] next_cursor;
        logic jumped;
    } answer_t;

    logic [7:0] var_file [bie_pkg::NUM_VARIABLES_DEF];
    logic [15:0] labels [bie_pkg::NUM_LABELS_DEF];
    logic [15:0] ret_cursor;
    logic [7:0] user_fn;
    logic [7:0] last_err;
    logic [7:0] var_tag;
    logic [7:0] imm_tag;
    answer_t pending_answers [$];

    function automatic logic [7:0] fetch(input logic [7:0] tag, input logic [7:0] val);
        return (tag == var_tag) ? var_file[val[VB-1:0]] : val;
    endfunction

    // Label slot selected by a resolved operand, taken by its low bits.
    function automatic logic [LB-1:0] label_idx(input logic [7:0] tag,
                                                input logic [7:0] val);
        logic [7:0] v;
        v = fetch(tag, val);
        return v[LB-1:0];
    endfunction

    // Executes one instruction on the shadow state and returns its result.
    function automatic answer_t execute_instr();
        answer_t a;
        logic [7:0] x, y, r, op;
        logic [15:0] cur;
        a = '0;
        op = in_mon.opcode;
        cur = in_mon.cursor;
        a.next_cursor = cur;
        if (in_mon.end_marker != bie_pkg::END_BYTE) begin
            last_err = bie_pkg::ERR_TERMINATOR;
            a.status = bie_pkg::ST_PROG_ERR;
        end
        else if (in_mon.cmd) begin
            if (op == bie_pkg::OP_LABEL)
                labels[label_idx(in_mon.type_a, in_mon.operand_a)] = cur;
            else if (op == bie_pkg::OP_EXIT)
                a.status = bie_pkg::ST_EXIT;
            else
                a.status = bie_pkg::ST_NOT_LABEL;
        end
        else if (op <= bie_pkg::OP_DIV || (op >= bie_pkg::OP_EQ && op <= bie_pkg::OP_LT)) begin
            if (op == bie_pkg::OP_ASSIGN) begin
                if (in_mon.type_a != var_tag || in_mon.type_b != imm_tag) begin
                    last_err = bie_pkg::ERR_ASSIGN;
                    a.status = bie_pkg::ST_PROG_ERR;
                end
                else
                    var_file[in_mon.operand_a[VB-1:0]] = in_mon.operand_b;
            end
            else if (op == bie_pkg::OP_MOVE) begin
                if (in_mon.type_a != var_tag || in_mon.type_b != var_tag) begin
                    last_err = bie_pkg::ERR_MOVE;
                    a.status = bie_pkg::ST_PROG_ERR;
                end
                else
                    var_file[in_mon.operand_b[VB-1:0]] = var_file[in_mon.operand_a[VB-1:0]];
            end
            else if (in_mon.type_c != var_tag) begin
                // Destination errors are numbered after the opcode.
                last_err = (op <= bie_pkg::OP_DIV) ? op + 8'd1 : op - 8'd1;
                a.status = bie_pkg::ST_PROG_ERR;
            end
            else begin
                x = fetch(in_mon.type_a, in_mon.operand_a);
                y = fetch(in_mon.type_b, in_mon.operand_b);
                case (op)
                    bie_pkg::OP_ADD: r = x + y;
                    bie_pkg::OP_SUB: r = x - y;
                    bie_pkg::OP_MUL: r = x * y;
                    bie_pkg::OP_DIV: r = (y == 8'd0) ? 8'hFF : x / y;
                    bie_pkg::OP_EQ: r = {7'd0, x == y};
                    bie_pkg::OP_GT: r = {7'd0, x > y};
                    default: r = {7'd0, x < y};
                endcase
                var_file[in_mon.operand_c[VB-1:0]] = r;
            end
        end
        else begin
            case (op)
                bie_pkg::OP_INCR: var_file[in_mon.operand_a[VB-1:0]] += 8'd1;
                bie_pkg::OP_DECR: var_file[in_mon.operand_a[VB-1:0]] -= 8'd1;
                bie_pkg::OP_NOT, bie_pkg::OP_BOOL:
                    if (in_mon.type_a != var_tag) begin
                        last_err = (op == bie_pkg::OP_NOT) ? bie_pkg::ERR_NOT
                                                           : bie_pkg::ERR_BOOL;
                        a.status = bie_pkg::ST_PROG_ERR;
                    end
                    else begin
                        r = var_file[in_mon.operand_a[VB-1:0]];
                        var_file[in_mon.operand_a[VB-1:0]] =
                            (op == bie_pkg::OP_NOT) ? {7'd0, r == 8'd0} : {7'd0, r != 8'd0};
                    end
                bie_pkg::OP_LABEL:
                    labels[label_idx(in_mon.type_a, in_mon.operand_a)] = cur;
                bie_pkg::OP_JUMP: begin
                    ret_cursor = cur;
                    a.next_cursor = labels[label_idx(in_mon.type_a, in_mon.operand_a)];
                    a.jumped = 1'b1;
                end
                bie_pkg::OP_CJUMP:
                    if (fetch(in_mon.type_a, in_mon.operand_a)
                            == fetch(in_mon.type_b, in_mon.operand_b)) begin
                        a.next_cursor = labels[label_idx(in_mon.type_c, in_mon.operand_c)];
                        a.jumped = 1'b1;
                    end
                bie_pkg::OP_RETURN: begin
                    a.next_cursor = ret_cursor;
                    a.jumped = 1'b1;
                end
                bie_pkg::OP_DEBUG: begin
                    a.debug_valid = 1'b1;
                    a.debug_value = fetch(in_mon.type_a, in_mon.operand_a);
                end
                bie_pkg::OP_UERR: begin
                    last_err = fetch(in_mon.type_a, in_mon.operand_a);
                    a.status = bie_pkg::ST_USER_ERR;
                end
                bie_pkg::OP_SETFN: user_fn = fetch(in_mon.type_a, in_mon.operand_a);
                bie_pkg::OP_CALL: begin
                    a.call_valid = 1'b1;
                    a.call_function = user_fn;
                    a.call_arg_one = fetch(in_mon.type_a, in_mon.operand_a);
                    a.call_arg_two = fetch(in_mon.type_b, in_mon.operand_b);
                    a.call_arg_three = fetch(in_mon.type_c, in_mon.operand_c);
                end
                bie_pkg::OP_EXIT: a.status = bie_pkg::ST_EXIT;
                default: begin
                    last_err = bie_pkg::ERR_OPCODE;
                    a.status = bie_pkg::ST_PROG_ERR;
                end
            endcase
        end
        a.error_code = last_err;
        return a;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic compare_answer();
        answer_t want;
        if (pending_answers.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
            return;
        end
        want = pending_answers.pop_front();
        if (out_mon.status != want.status)
            report_mismatch("status", out_mon.status, want.status);
        if (out_mon.error_code != want.error_code)
            report_mismatch("error_code", out_mon.error_code, want.error_code);
        if (out_mon.debug_valid != want.debug_valid)
            report_mismatch("debug_valid", out_mon.debug_valid, want.debug_valid);
        if (out_mon.debug_value != want.debug_value)
            report_mismatch("debug_value", out_mon.debug_value, want.debug_value);
        if (out_mon.call_valid != want.call_valid)
            report_mismatch("call_valid", out_mon.call_valid, want.call_valid);
        if (out_mon.call_function != want.call_function)
            report_mismatch("call_function", out_mon.call_function, want.call_function);
        if (out_mon.call_arg_one != want.call_arg_one)
            report_mismatch("call_arg_one", out_mon.call_arg_one, want.call_arg_one);
        if (out_mon.call_arg_two != want.call_arg_two)
            report_mismatch("call_arg_two", out_mon.call_arg_two, want.call_arg_two);
        if (out_mon.call_arg_three != want.call_arg_three)
            report_mismatch("call_arg_three", out_mon.call_arg_three, want.call_arg_three);
        if (out_mon.next_cursor != want.next_cursor)
            report_mismatch("next_cursor", out_mon.next_cursor, want.next_cursor);
        if (out_mon.jumped != want.jumped)
            report_mismatch("jumped", out_mon.jumped, want.jumped);
    endtask

    function automatic int outstanding();
        return pending_answers.size();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            foreach (var_file[i]) var_file[i] = '0;
            foreach (labels[i]) labels[i] = '0;
            ret_cursor = '0;
            user_fn = '0;
            last_err = '0;
            var_tag = 8'd0;
            imm_tag = 8'd1;
            pending_answers.delete();
            errors = 0;
        end
        else begin
            if (out_mon.valid && out_mon.ready)
                compare_answer();
            if (in_mon.valid && in_mon.ready)
                pending_answers.push_back(execute_instr());
            if (cfg_mon.cfg_we) begin
                if (cfg_mon.cfg_index == bie_pkg::REG_VARIABLE_TAG)
                    var_tag = cfg_mon.cfg_data;
                else
                    imm_tag = cfg_mon.cfg_data;
            end
        end
    end
endmodule

@@ sim/bytecode_instruction_executor_test.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for the bytecode executor. The checker beside the
// block keeps its own copy of the machine state and compares every result.
module bytecode_instruction_executor_test;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int errors;

    bie_in_if in_ch ();
    bie_out_if out_ch ();
    bie_cfg_if cfg ();

    // Idle percentages for the sender and the receiver, set per phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // When set, the receiver holds ready low for this many cycles.
    int hold_off_cycles = 0;
    logic [7:0] var_tag_now = 8'd0;
    logic [7:0] imm_tag_now = 8'd1;

    bytecode_instruction_executor dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg.cfg_we),
        .cfg_index(cfg.cfg_index),
        .cfg_data(cfg.cfg_data)
    );

    bie_checker u_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_mon(in_ch.sink),
        .out_mon(out_ch.sink),
        .cfg_mon(cfg.sink),
        .errors(errors)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver decides ready every cycle; a long hold-off overrides it.
    initial
    begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_cycles > 0) begin
                out_ch.ready <= 1'b0;
                hold_off_cycles--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Sends one instruction beat, with a random gap in front of it when the
    // sender is idling. Valid stays high after the beat is taken until the
    // next beat replaces it or the sender goes idle.
    task automatic send_beat(input logic cmd, input logic [7:0] op,
                             input logic [7:0] ta, input logic [7:0] va,
                             input logic [7:0] tb, input logic [7:0] vb,
                             input logic [7:0] tc, input logic [7:0] vc,
                             input logic [7:0] endb, input logic [15:0] cur);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.opcode <= op;
        in_ch.type_a <= ta;
        in_ch.operand_a <= va;
        in_ch.type_b <= tb;
        in_ch.operand_b <= vb;
        in_ch.type_c <= tc;
        in_ch.operand_c <= vc;
        in_ch.end_marker <= endb;
        in_ch.cursor <= cur;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Picks an operand tag: mostly one of the two configured tags.
    function automatic logic [7:0] pick_tag();
        int r;
        r = $urandom_range(9);
        if (r < 5) return var_tag_now;
        if (r < 9) return imm_tag_now;
        return 8'($urandom_range(255));
    endfunction

    // A well-formed instruction with random content; now and then a broken
    // terminator, an unknown opcode or the label scan mode.
    task automatic send_random_instr();
        logic [7:0] op;
        logic [7:0] endb;
        logic cmd;
        op = 8'($urandom_range(bie_pkg::OP_EXIT));
        if ($urandom_range(29) == 0) op = 8'($urandom_range(255));
        endb = ($urandom_range(24) == 0) ? 8'($urandom_range(255)) : bie_pkg::END_BYTE;
        cmd = ($urandom_range(9) == 0);
        send_beat(cmd, op, pick_tag(), 8'($urandom_range(255)),
                  pick_tag(), 8'($urandom_range(255)),
                  pick_tag(), 8'($urandom_range(255)),
                  endb, 16'($urandom_range(16'hFFFF)));
    endtask

    // Stops offering, waits for all outstanding results, then lets the
    // block settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (u_check.outstanding() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_tags(input logic [7:0] vt, input logic [7:0] it);
        cfg.cfg_we <= 1'b1;
        cfg.cfg_index <= bie_pkg::REG_VARIABLE_TAG;
        cfg.cfg_data <= vt;
        @(posedge clk);
        cfg.cfg_index <= bie_pkg::REG_IMMEDIATE_TAG;
        cfg.cfg_data <= it;
        @(posedge clk);
        cfg.cfg_we <= 1'b0;
        var_tag_now = vt;
        imm_tag_now = it;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_random_instr();
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.cmd = 1'b0;
        in_ch.opcode = '0;
        in_ch.type_a = '0;
        in_ch.operand_a = '0;
        in_ch.type_b = '0;
        in_ch.operand_b = '0;
        in_ch.type_c = '0;
        in_ch.operand_c = '0;
        in_ch.end_marker = '0;
        in_ch.cursor = '0;
        cfg.cfg_we = 1'b0;
        cfg.cfg_index = bie_pkg::REG_VARIABLE_TAG;
        cfg.cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: every opcode, some at field extremes, with the reset tags.
        send_beat(1'b0, bie_pkg::OP_ASSIGN, 8'd0, 8'd5, 8'd1, 8'd200, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd1);
        send_beat(1'b0, bie_pkg::OP_ASSIGN, 8'd0, 8'hFF, 8'd1, 8'hFF, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd2);
        send_beat(1'b0, bie_pkg::OP_ASSIGN, 8'd1, 8'd5, 8'd1, 8'd3, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd3);
        send_beat(1'b0, bie_pkg::OP_MOVE, 8'd0, 8'd5, 8'd0, 8'd6, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd4);
        send_beat(1'b0, bie_pkg::OP_MOVE, 8'd0, 8'd5, 8'd9, 8'd6, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd5);
        send_beat(1'b0, bie_pkg::OP_ADD, 8'd0, 8'd5, 8'd0, 8'h3F, 8'd0, 8'd7,
                  bie_pkg::END_BYTE, 16'd6);
        send_beat(1'b0, bie_pkg::OP_SUB, 8'd1, 8'd0, 8'd1, 8'd1, 8'd0, 8'd8,
                  bie_pkg::END_BYTE, 16'd7);
        send_beat(1'b0, bie_pkg::OP_MUL, 8'd1, 8'hFF, 8'd1, 8'hFF, 8'd0, 8'd9,
                  bie_pkg::END_BYTE, 16'd8);
        // Division by zero gives all ones; a bad destination tag is an error.
        send_beat(1'b0, bie_pkg::OP_DIV, 8'd1, 8'd77, 8'd1, 8'd0, 8'd0, 8'd10,
                  bie_pkg::END_BYTE, 16'd9);
        send_beat(1'b0, bie_pkg::OP_DIV, 8'd1, 8'd77, 8'd1, 8'd7, 8'd5, 8'd10,
                  bie_pkg::END_BYTE, 16'd10);
        send_beat(1'b0, bie_pkg::OP_DIV, 8'd1, 8'd200, 8'd1, 8'd7, 8'd0, 8'd10,
                  bie_pkg::END_BYTE, 16'd10);
        send_beat(1'b0, bie_pkg::OP_INCR, 8'd7, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd11);
        send_beat(1'b0, bie_pkg::OP_DECR, 8'd0, 8'd11, 8'd0, 8'd0, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd12);
        send_beat(1'b0, bie_pkg::OP_NOT, 8'd0, 8'd11, 8'd0, 8'd0, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd13);
        send_beat(1'b0, bie_pkg::OP_BOOL, 8'd1, 8'd11, 8'd0, 8'd0, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd14);
        send_beat(1'b0, bie_pkg::OP_EQ, 8'd1, 8'd3, 8'd1, 8'd3, 8'd3, 8'd12,
                  bie_pkg::END_BYTE, 16'd15);
        send_beat(1'b0, bie_pkg::OP_GT, 8'd1, 8'd4, 8'd1, 8'd3, 8'd0, 8'd12,
                  bie_pkg::END_BYTE, 16'd16);
        send_beat(1'b0, bie_pkg::OP_LT, 8'd1, 8'd4, 8'd1, 8'd3, 8'd0, 8'd13,
                  bie_pkg::END_BYTE, 16'd17);
        send_beat(1'b0, bie_pkg::OP_LABEL, 8'd1, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'hFFFF);
        send_beat(1'b1, bie_pkg::OP_LABEL, 8'd1, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'h1234);
        send_beat(1'b0, bie_pkg::OP_JUMP, 8'd1, 8'd35, 8'd0, 8'd0, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd20);
        send_beat(1'b0, bie_pkg::OP_CJUMP, 8'd1, 8'd2, 8'd1, 8'd2, 8'd1, 8'd31,
                  bie_pkg::END_BYTE, 16'd21);
        send_beat(1'b0, bie_pkg::OP_RETURN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd22);
        send_beat(1'b0, bie_pkg::OP_DEBUG, 8'd0, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd23);
        send_beat(1'b0, bie_pkg::OP_SETFN, 8'd1, 8'd99, 8'd0, 8'd0, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd24);
        send_beat(1'b0, bie_pkg::OP_CALL, 8'd0, 8'd5, 8'd1, 8'd6, 8'd0, 8'd6,
                  bie_pkg::END_BYTE, 16'd25);
        send_beat(1'b0, bie_pkg::OP_UERR, 8'd1, 8'hEE, 8'd0, 8'd0, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd26);
        send_beat(1'b1, bie_pkg::OP_EXIT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd27);
        send_beat(1'b1, bie_pkg::OP_ADD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd28);
        send_beat(1'b0, bie_pkg::OP_EXIT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd29);
        send_beat(1'b0, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                  bie_pkg::END_BYTE, 16'd30);
        send_beat(1'b1, bie_pkg::OP_LABEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                  8'h45, 16'd31);
        drain();

        // Random phases across tag settings and idling patterns.
        run_random(250);
        drain();
        write_tags(8'hFF, 8'h00);
        send_idle_pct = 86;
        run_random(200);
        drain();
        // Both tags equal: such operands read variables.
        write_tags(8'h5A, 8'h5A);
        send_idle_pct = 0;
        recv_stall_pct = 86;
        run_random(200);
        drain();
        write_tags(8'h00, 8'hFF);
        send_idle_pct = 9;
        recv_stall_pct = 9;
        run_random(250);
        drain();
        // Long receiver hold-off while the sender keeps offering beats.
        write_tags(8'h00, 8'h01);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 300;
        run_random(200);
        drain();
        write_tags(8'hA5, 8'h5A);
        run_random(220);
        drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

@@ files.f @@
rtl/bie_pkg.sv
rtl/bie_if.sv
rtl/bie_alu.sv
rtl/bytecode_instruction_executor.sv
sim/bie_tb_if.sv
sim/bie_checker.sv
sim/bytecode_instruction_executor_test.sv
